@@ rtl/core/sfpdt_pkg.sv @@
`timescale 1ns / 1ps

package sfpdt_pkg;

   // ASCII codes used in the text.
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_DOT   = 8'h2E;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;
   localparam logic [7:0] CHAR_NUL   = 8'h00;

   localparam int unsigned VALUE_WIDTH = 25;

   // Position of an integer digit, most significant first.
   localparam logic [1:0] DIGIT_HUNDREDS = 2'd0;
   localparam logic [1:0] DIGIT_TENS     = 2'd1;
   localparam logic [1:0] DIGIT_ONES     = 2'd2;
   localparam logic [1:0] INT_DIGITS     = 2'd3;

   localparam int unsigned QUEUE_DEPTH = 2;

   // Classified header of one number, passed from the front to the back.
   typedef struct packed {
      logic       negative;
      logic [1:0] int_count;
      logic [3:0] hundreds;
      logic [3:0] tens;
      logic [3:0] ones;
   } head_type;

endpackage

@@ rtl/core/sfpdt_if.sv @@
`timescale 1ns / 1ps

interface sfpdt_req_if;
   logic        valid;
   logic        ready;
   logic [24:0] value_fixed;

   modport source (output valid, output value_fixed, input ready);
   modport sink (input valid, input value_fixed, output ready);
endinterface

interface sfpdt_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] text_char;
   logic       last_char;

   modport source (output valid, output text_char, output last_char, input ready);
   modport sink (input valid, input text_char, input last_char, output ready);
endinterface

@@ rtl/core/sfpdt_front.sv @@
`timescale 1ns / 1ps

module sfpdt_front
   import sfpdt_pkg::*;
#(
   parameter int unsigned FRAC_BITS = 16
) (
   sfpdt_req_if.sink              req_if,
   output logic                   push_valid,
   input  logic                   push_ready,
   output head_type               push_head,
   output logic [FRAC_BITS-1:0]   push_frac
);

   localparam int unsigned CW = (FRAC_BITS + 8 > VALUE_WIDTH) ? FRAC_BITS + 8 : VALUE_WIDTH;
   localparam logic [CW-1:0] MAG_MAX = CW'((64'd256 << FRAC_BITS) - 64'd1);

   logic                   negative;
   logic [VALUE_WIDTH-1:0] mag;
   logic [CW-1:0]          mag_ext;
   logic [CW-1:0]          mag_sat;
   logic [7:0]             ipart;
   logic [3:0]             hundreds;
   logic [7:0]             rem;
   logic [15:0]            tens_prod;
   logic [3:0]             tens;
   logic [7:0]             ones_full;
   logic [3:0]             ones;

   assign negative = req_if.value_fixed[VALUE_WIDTH-1];

   // The most negative pattern negates to itself as an unsigned magnitude of 2^24.
   assign mag     = negative ? (~req_if.value_fixed + 1'b1) : req_if.value_fixed;
   assign mag_ext = CW'(mag);
   assign mag_sat = (mag_ext > MAG_MAX) ? MAG_MAX : mag_ext;
   assign ipart   = mag_sat[FRAC_BITS+7:FRAC_BITS];

   always_comb begin
      if (ipart >= 8'd200) begin
         hundreds = 4'd2;
         rem      = ipart - 8'd200;
      end else if (ipart >= 8'd100) begin
         hundreds = 4'd1;
         rem      = ipart - 8'd100;
      end else begin
         hundreds = 4'd0;
         rem      = ipart;
      end
   end

   // Division by ten through the reciprocal 205 / 2048, exact for every remainder here (below 100).
   assign tens_prod = 16'(rem) * 16'd205;
   assign tens      = tens_prod[14:11];
   assign ones_full = rem - 8'(tens) * 8'd10;
   assign ones      = ones_full[3:0];

   always_comb begin
      push_head.negative = negative;
      push_head.hundreds = hundreds;
      push_head.tens     = tens;
      push_head.ones     = ones;
      if (hundreds != 4'd0) begin
         push_head.int_count = 2'd3;
      end else if (tens != 4'd0) begin
         push_head.int_count = 2'd2;
      end else begin
         push_head.int_count = 2'd1;
      end
   end

   assign push_frac    = mag_sat[FRAC_BITS-1:0];
   assign push_valid   = req_if.valid;
   assign req_if.ready = push_ready;

endmodule

@@ rtl/core/sfpdt_queue.sv @@
`timescale 1ns / 1ps

module sfpdt_queue
   import sfpdt_pkg::*;
#(
   parameter int unsigned WIDTH = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  logic [WIDTH-1:0] in_data,
   output logic             out_valid,
   input  logic             out_ready,
   output logic [WIDTH-1:0] out_data
);

   localparam int unsigned PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int unsigned CNW = $clog2(QUEUE_DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [QUEUE_DEPTH];
   logic [PW-1:0]    wr_ptr_ff;
   logic [PW-1:0]    wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff;
   logic [PW-1:0]    rd_ptr_in;
   logic [CNW-1:0]   count_ff;
   logic [CNW-1:0]   count_in;
   logic             push;
   logic             pop;

   assign in_ready  = (count_ff != CNW'(QUEUE_DEPTH));
   assign out_valid = (count_ff != '0);
   assign out_data  = slot_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= in_data;
      end
   end

endmodule

@@ rtl/core/sfpdt_back.sv @@
`timescale 1ns / 1ps

module sfpdt_back
   import sfpdt_pkg::*;
#(
   parameter int unsigned FRAC_BITS   = 16,
   parameter int unsigned FRAC_DIGITS = 4
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 q_valid,
   output logic                 q_ready,
   input  head_type             q_head,
   input  logic [FRAC_BITS-1:0] q_frac,
   sfpdt_rsp_if.source          rsp_if
);

   localparam int unsigned FCW = (FRAC_DIGITS > 1) ? $clog2(FRAC_DIGITS) : 1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SIGN,
      ST_INT,
      ST_DOT,
      ST_FRAC,
      ST_NUL
   } state_type;

   state_type            state_ff;
   state_type            state_in;
   head_type             head_ff;
   head_type             head_in;
   logic [FRAC_BITS-1:0] frac_ff;
   logic [FRAC_BITS-1:0] frac_in;
   logic [1:0]           idx_ff;
   logic [1:0]           idx_in;
   logic [FCW-1:0]       cnt_ff;
   logic [FCW-1:0]       cnt_in;
   logic                 valid_ff;
   logic                 valid_in;
   logic [7:0]           char_ff;
   logic [7:0]           char_in;
   logic                 last_ff;
   logic                 last_in;
   logic                 adv;
   logic                 load;
   logic [3:0]           int_digit;
   logic [FRAC_BITS+3:0] frac_prod;

   // The output register moves on when it is empty or being taken.
   assign adv = !valid_ff || rsp_if.ready;

   always_comb begin
      case (idx_ff)
         DIGIT_HUNDREDS: int_digit = head_ff.hundreds;
         DIGIT_TENS:     int_digit = head_ff.tens;
         default:        int_digit = head_ff.ones;
      endcase
   end

   // Times ten: the top four bits are the next fraction digit.
   assign frac_prod = ({4'b0, frac_ff} << 3) + ({4'b0, frac_ff} << 1);

   always_comb begin
      state_in = state_ff;
      head_in  = head_ff;
      frac_in  = frac_ff;
      idx_in   = idx_ff;
      cnt_in   = cnt_ff;
      valid_in = valid_ff;
      char_in  = char_ff;
      last_in  = last_ff;
      load     = 1'b0;
      q_ready  = 1'b0;
      if (adv) begin
         unique case (state_ff)
            ST_IDLE: begin
               valid_in = 1'b0;
               load     = 1'b1;
            end
            ST_SIGN: begin
               valid_in = 1'b1;
               char_in  = CHAR_MINUS;
               last_in  = 1'b0;
               state_in = ST_INT;
            end
            ST_INT: begin
               valid_in = 1'b1;
               char_in  = CHAR_ZERO + {4'b0, int_digit};
               last_in  = 1'b0;
               if (idx_ff == DIGIT_ONES) begin
                  state_in = ST_DOT;
               end else begin
                  idx_in = idx_ff + 1'b1;
               end
            end
            ST_DOT: begin
               valid_in = 1'b1;
               char_in  = CHAR_DOT;
               last_in  = 1'b0;
               cnt_in   = '0;
               state_in = ST_FRAC;
            end
            ST_FRAC: begin
               valid_in = 1'b1;
               char_in  = CHAR_ZERO + {4'b0, frac_prod[FRAC_BITS+3:FRAC_BITS]};
               last_in  = 1'b0;
               frac_in  = frac_prod[FRAC_BITS-1:0];
               if (cnt_ff == FCW'(FRAC_DIGITS - 1)) begin
                  state_in = ST_NUL;
               end else begin
                  cnt_in = cnt_ff + 1'b1;
               end
            end
            ST_NUL: begin
               valid_in = 1'b1;
               char_in  = CHAR_NUL;
               last_in  = 1'b1;
               load     = 1'b1;
            end
            default: begin
               state_in = ST_IDLE;
            end
         endcase
         // The next number starts in the same cycle as the terminating byte.
         if (load) begin
            if (q_valid) begin
               q_ready  = 1'b1;
               head_in  = q_head;
               frac_in  = q_frac;
               idx_in   = INT_DIGITS - q_head.int_count;
               state_in = q_head.negative ? ST_SIGN : ST_INT;
            end else begin
               state_in = ST_IDLE;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
      head_ff <= head_in;
      frac_ff <= frac_in;
      idx_ff  <= idx_in;
      cnt_ff  <= cnt_in;
      char_ff <= char_in;
      last_ff <= last_in;
   end

   assign rsp_if.valid     = valid_ff;
   assign rsp_if.text_char = char_ff;
   assign rsp_if.last_char = last_ff;

endmodule

@@ rtl/core/signed_fixed_point_decimal_text.sv @@
`timescale 1ns / 1ps

// Prints one signed fixed-point number per request transaction as decimal ASCII text, one
// character per response transaction: an optional '-', the integer part without leading
// zeros (at most three digits, the magnitude saturating just below 256), '.', FRAC_DIGITS
// truncated fraction digits and a zero byte flagged by last_char. A number has from 1 + 1 +
// FRAC_DIGITS + 1 up to 3 + 1 + FRAC_DIGITS + 2 characters (7 to 10 at the defaults), formed
// by the output sequencer at one character per cycle while the receiver is ready. When the
// block is empty, a taken request passes the queue and the sequencer state to the output.
// A two-entry queue holds classified numbers, so requests are taken while the text of an
// earlier number is still going out.

module signed_fixed_point_decimal_text
   import sfpdt_pkg::*;
#(
   parameter int unsigned FRAC_BITS   = 16,
   parameter int unsigned FRAC_DIGITS = 4
) (
   input  logic        clock,
   input  logic        reset,
   sfpdt_req_if.sink   req_if,
   sfpdt_rsp_if.source rsp_if
);

   localparam int unsigned QW = $bits(head_type) + FRAC_BITS;

   logic                 push_valid;
   logic                 push_ready;
   head_type             push_head;
   logic [FRAC_BITS-1:0] push_frac;
   logic                 q_valid;
   logic                 q_ready;
   logic [QW-1:0]        q_data;
   head_type             q_head;
   logic [FRAC_BITS-1:0] q_frac;

   sfpdt_front #(
      .FRAC_BITS (FRAC_BITS)
   ) u_front (
      .req_if     (req_if),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_head  (push_head),
      .push_frac  (push_frac)
   );

   sfpdt_queue #(
      .WIDTH (QW)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (push_valid),
      .in_ready  (push_ready),
      .in_data   ({push_head, push_frac}),
      .out_valid (q_valid),
      .out_ready (q_ready),
      .out_data  (q_data)
   );

   assign q_head = q_data[QW-1:FRAC_BITS];
   assign q_frac = q_data[FRAC_BITS-1:0];

   sfpdt_back #(
      .FRAC_BITS   (FRAC_BITS),
      .FRAC_DIGITS (FRAC_DIGITS)
   ) u_back (
      .clock   (clock),
      .reset   (reset),
      .q_valid (q_valid),
      .q_ready (q_ready),
      .q_head  (q_head),
      .q_frac  (q_frac),
      .rsp_if  (rsp_if)
   );

endmodule

@@ rtl/core/sfpdt_checker.sv @@
`timescale 1ns / 1ps

module sfpdt_checker
   import sfpdt_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_text_char,
   input logic       rsp_last_char
);

   // Nothing is shown in the cycle after reset.
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_text_char)
                                  && $stable(rsp_last_char))
      else $error("stalled response changed");

   // The flagged byte is the zero byte, and only it.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_last_char == (rsp_text_char == CHAR_NUL)))
      else $error("last flag and zero byte disagree");

   // The byte right after a taken zero byte, if shown, is a sign or a digit.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_last_char |=> !rsp_valid
         || rsp_text_char == CHAR_MINUS
         || (rsp_text_char >= CHAR_ZERO && rsp_text_char <= CHAR_NINE))
      else $error("text starts with a bad character");

endmodule

bind signed_fixed_point_decimal_text sfpdt_checker u_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_if.valid),
   .rsp_ready     (rsp_if.ready),
   .rsp_text_char (rsp_if.text_char),
   .rsp_last_char (rsp_if.last_char)
);

@@ sim/tb_signed_fixed_point_decimal_text.sv @@
`timescale 1ns / 1ps

module tb_signed_fixed_point_decimal_text;
   import sfpdt_pkg::*;

   localparam int FRAC_BITS      = 16;
   localparam int FRAC_DIGITS    = 4;
   localparam int WATCHDOG_LIMIT = 1000;
   localparam int MAX_SEND_GAP   = 20;
   localparam int LONG_HOLD      = 150;
   localparam logic [25:0] MAG_LIMIT = (26'd256 << FRAC_BITS) - 26'd1;
   localparam logic [24:0] MOST_NEGATIVE = 25'h1000000;

   typedef struct packed {
      logic [7:0] ch;
      logic       last;
   } text_entry_type;

   logic clock = 1'b0;
   logic reset;

   sfpdt_req_if req_bus ();
   sfpdt_rsp_if rsp_bus ();

   signed_fixed_point_decimal_text uut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_bus),
      .rsp_if (rsp_bus)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   text_entry_type expected_text[$];
   int error_count      = 0;
   int numbers_sent     = 0;
   int negatives_sent   = 0;
   int saturated_sent   = 0;
   int chars_checked    = 0;
   int send_idle_pct    = 0;
   int rsp_stall_pct    = 0;
   int hold_request     = 0;
   int hold_left        = 0;
   int quiet_cycles     = 0;

   task automatic report_mismatch(input string what);
      $display("ERROR @%0t: %s", $time, what);
      error_count++;
   endtask

   function automatic void push_char(input logic [7:0] ch, input logic last);
      text_entry_type entry;
      entry.ch   = ch;
      entry.last = last;
      expected_text.push_back(entry);
   endfunction

   // Builds the expected character stream of one number.
   function automatic void predict_text(input logic [24:0] value);
      logic [25:0] mag;
      logic [7:0]  int_part;
      logic [31:0] frac;
      logic [31:0] scale;
      logic [31:0] frac_dec;
      logic [3:0]  frac_digit[FRAC_DIGITS];
      int k;
      scale = 1;
      if (value[24]) begin
         mag = 26'h2000000 - {1'b0, value};
         push_char(CHAR_MINUS, 1'b0);
         negatives_sent++;
      end else begin
         mag = {1'b0, value};
      end
      if (mag > MAG_LIMIT) begin
         mag = MAG_LIMIT;
         saturated_sent++;
      end
      int_part = 8'(mag >> FRAC_BITS);
      frac = 32'(mag & ((26'd1 << FRAC_BITS) - 26'd1));
      if (int_part == 8'd0) begin
         push_char(CHAR_ZERO, 1'b0);
      end else begin
         if (int_part >= 8'd100)
            push_char(CHAR_ZERO + 8'(int_part / 8'd100), 1'b0);
         if (int_part >= 8'd10)
            push_char(CHAR_ZERO + 8'((int_part / 8'd10) % 8'd10), 1'b0);
         push_char(CHAR_ZERO + 8'(int_part % 8'd10), 1'b0);
      end
      push_char(CHAR_DOT, 1'b0);
      for (k = 0; k < FRAC_DIGITS; k++)
         scale = scale * 10;
      frac_dec = (frac * scale) >> FRAC_BITS;
      for (k = FRAC_DIGITS - 1; k >= 0; k--) begin
         frac_digit[k] = 4'(frac_dec % 10);
         frac_dec = frac_dec / 10;
      end
      for (k = 0; k < FRAC_DIGITS; k++)
         push_char(CHAR_ZERO + 8'(frac_digit[k]), 1'b0);
      push_char(CHAR_NUL, 1'b1);
   endfunction

   // Called at a rising edge; returns at the rising edge where the number is taken.
   task automatic send_value(input logic [24:0] value);
      int gap;
      gap = 0;
      while (gap < MAX_SEND_GAP && $urandom_range(99) < send_idle_pct)
         gap++;
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid       <= 1'b1;
      req_bus.value_fixed <= value;
      do @(negedge clock); while (!req_bus.ready);
      @(posedge clock);
      predict_text(value);
      numbers_sent++;
   endtask

   task automatic wait_for_drain();
      req_bus.valid <= 1'b0;
      while (expected_text.size() != 0)
         @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   function automatic logic [24:0] random_fixed();
      logic [23:0] mag;
      logic [24:0] value;
      int kind;
      kind = $urandom_range(9);
      mag = 24'($urandom);
      case (kind)
         4, 5: mag[23:16] = 8'($urandom_range(9));
         6: mag[23:16] = 8'($urandom_range(10, 99));
         7: mag[23:16] = 8'($urandom_range(100, 255));
         8: mag[23:16] = 8'd0;
         9: begin
            mag[15:0] = ($urandom_range(1) == 0) ? 16'h0000 : 16'hFFFF;
            if ($urandom_range(3) == 0)
               mag[23:16] = ($urandom_range(1) == 0) ? 8'd99 : 8'd255;
         end
         default: ;
      endcase
      if (kind < 4)
         value = 25'($urandom);
      else if (kind == 9 && $urandom_range(7) == 0)
         value = MOST_NEGATIVE;
      else if ($urandom_range(1) == 0)
         value = -{1'b0, mag};
      else
         value = {1'b0, mag};
      return value;
   endfunction

   task automatic test_directed_values();
      logic [24:0] values[$];
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      values = '{25'h0000000, 25'h0000001, -25'sd1, 25'h0010000, -25'h0010000,
                 25'h0FFFFFF, -25'h0FFFFFF, MOST_NEGATIVE, 25'h000FFFF, -25'h0008000,
                 25'h0098000, 25'h00A0000, 25'h0063FFF, 25'h0640000, 25'h07B74BC,
                 25'h07FFFFF, 25'h0800000, 25'h0090000, -25'h0630001, 25'h1555555,
                 25'h0AAAAAA, 25'h0000007};
      foreach (values[i])
         send_value(values[i]);
      wait_for_drain();
   endtask

   task automatic test_random_phase(input int sender_idle, input int receiver_stall,
                                    input int count);
      send_idle_pct = sender_idle;
      rsp_stall_pct = receiver_stall;
      repeat (count)
         send_value(random_fixed());
      wait_for_drain();
   endtask

   // The receiver stops for a long stretch while numbers keep coming, so the
   // internal queue fills up and the input side has to stall.
   task automatic test_output_backpressure();
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      hold_request = LONG_HOLD;
      repeat (12)
         send_value(random_fixed());
      wait_for_drain();
   endtask

   initial begin
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request > 0) begin
            hold_left = hold_request;
            hold_request = 0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= ($urandom_range(99) >= rsp_stall_pct);
         end
      end
   end

   // Outputs are stable at the falling edge, so each transaction is checked there.
   always @(negedge clock) begin
      text_entry_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expected_text.size() == 0) begin
            report_mismatch($sformatf("unexpected character 8'h%02h last=%0b",
                                      rsp_bus.text_char, rsp_bus.last_char));
         end else begin
            want = expected_text.pop_front();
            chars_checked++;
            if (rsp_bus.text_char !== want.ch)
               report_mismatch($sformatf("text_char 8'h%02h, expected 8'h%02h",
                                         rsp_bus.text_char, want.ch));
            if (rsp_bus.last_char !== want.last)
               report_mismatch($sformatf("last_char %0b, expected %0b on 8'h%02h",
                                         rsp_bus.last_char, want.last, want.ch));
         end
      end
   end

   always @(negedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Timeout: no transaction for %0d cycles, %0d characters pending",
                     quiet_cycles, expected_text.size());
            $display("== FAIL ==");
            $finish;
         end
      end
   end

   initial begin
      reset               <= 1'b1;
      req_bus.valid       <= 1'b0;
      req_bus.value_fixed <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed_values();
      test_random_phase(0, 0, 90);
      test_random_phase(75, 0, 85);
      test_random_phase(0, 75, 85);
      test_random_phase(30, 30, 90);
      test_output_backpressure();

      repeat (12) @(posedge clock);
      if (expected_text.size() != 0)
         report_mismatch($sformatf("%0d characters never arrived", expected_text.size()));

      $display("Printed %0d numbers (%0d negative, %0d saturated), %0d characters checked.",
               numbers_sent, negatives_sent, saturated_sent, chars_checked);
      $display("Idle and stall mixes plus one long output hold; %0d mismatches.", error_count);
      if (error_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

@@ files.f @@
rtl/core/sfpdt_pkg.sv
rtl/core/sfpdt_if.sv
rtl/core/sfpdt_front.sv
rtl/core/sfpdt_queue.sv
rtl/core/sfpdt_back.sv
rtl/core/signed_fixed_point_decimal_text.sv
rtl/core/sfpdt_checker.sv
sim/tb_signed_fixed_point_decimal_text.sv
